/* design/olmr_pkg.sv */
// Package for the open-loop motor ramp generator.
// Holds formats, defaults, register indexes, the sequencer states and shared functions.
// No dependencies.
package olmr_pkg;

	localparam int unsigned TIMER_CLOCK_HZ = 168000000;

	localparam int unsigned OPND_W = 32;
	localparam int unsigned PROD_W = 2 * OPND_W;
	localparam int unsigned PHASE_SHIFT = 12;
	localparam int unsigned QUO_W = PROD_W + PHASE_SHIFT;
	localparam int unsigned RATE_W = 31;
	localparam int unsigned PHASE_W = 31;
	localparam int unsigned DIST_W = 64;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned LANES = 3;

	localparam logic signed [31:0] DEFAULT_VOLTAGE = 32'sd39322;
	localparam logic signed [31:0] DEFAULT_VELOCITY = 32'sd4115661;
	localparam logic [RATE_W-1:0] RESET_CURRENT_RATE = 31'd1310720;
	localparam logic [RATE_W-1:0] RESET_VOLTAGE_RATE = 31'd131072;
	localparam logic [RATE_W-1:0] RESET_VELOCITY_RATE = 31'd65536000;

	localparam logic [31:0] PIQ = 32'd843314857;
	localparam int unsigned TWO_PIQ = 1686629714;
	localparam logic signed [PHASE_W-1:0] PHASE_MIN = -31'sd843314857;
	localparam logic signed [PHASE_W-1:0] PHASE_MAX = 31'sd843314856;

	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_CURRENT  = 3'd0,
		REG_TARGET_VOLTAGE  = 3'd1,
		REG_TARGET_VELOCITY = 3'd2,
		REG_CURRENT_RATE    = 3'd3,
		REG_VOLTAGE_RATE    = 3'd4,
		REG_VELOCITY_RATE   = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SLEW,
		ST_PMUL,
		ST_PDIV,
		ST_PMOD,
		ST_WRAP,
		ST_OUT
	} state_t;

	// Clamps the target into [prev - step, prev + step].
	function automatic logic signed [31:0] slew_clamp(input logic signed [31:0] prev,
		input logic signed [31:0] target, input logic [PROD_W-1:0] step);
		logic signed [PROD_W+1:0] p;
		logic signed [PROD_W+1:0] s;
		logic signed [PROD_W+1:0] lo;
		logic signed [PROD_W+1:0] hi;
		logic signed [PROD_W+1:0] r;
		p = {{(PROD_W-30){prev[31]}}, prev};
		s = {2'b00, step};
		lo = p - s;
		hi = p + s;
		r = {{(PROD_W-30){target[31]}}, target};
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r[31:0];
	endfunction

	function automatic logic [OPND_W-1:0] magnitude(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

/* design/olmr_ifs.sv */
// Handshake channels of the ramp generator: update requests, results and register writes.
// Depends on olmr_pkg for field widths.
interface olmr_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] timestamp;
	logic        restart;
	modport source(output valid, timestamp, restart, input ready);
	modport sink(input valid, timestamp, restart, output ready);
endinterface

interface olmr_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [31:0]                   current_setpoint;
	logic signed [31:0]                   voltage_setpoint;
	logic signed [31:0]                   phase_velocity;
	logic signed [olmr_pkg::PHASE_W-1:0]  electrical_phase;
	logic signed [olmr_pkg::DIST_W-1:0]   travelled_angle;
	modport source(output valid, current_setpoint, voltage_setpoint, phase_velocity,
		electrical_phase, travelled_angle, input ready);
	modport sink(input valid, current_setpoint, voltage_setpoint, phase_velocity,
		electrical_phase, travelled_angle, output ready);
endinterface

interface olmr_setup_if;
	logic                              valid;
	logic                              ready;
	logic [olmr_pkg::CFG_IDX_W-1:0]    index;
	logic [31:0]                       data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* design/olmr_serial_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on olmr_pkg for operand widths.
module olmr_serial_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [olmr_pkg::OPND_W-1:0]   a,
	input  logic [olmr_pkg::OPND_W-1:0]   b,
	output logic                          done,
	output logic [olmr_pkg::PROD_W-1:0]   product
);
	localparam int unsigned W = olmr_pkg::OPND_W;
	localparam int unsigned CW = $clog2(W);

	logic [W-1:0]   a_q;
	logic [2*W-1:0] acc_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     sum;

	assign sum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			acc_q <= {{W{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign product = acc_q;
endmodule

/* design/olmr_serial_div.sv */
// Restoring divider by a constant, one quotient bit per cycle.
// Depends on olmr_pkg for the defaults of its divisor and width parameters.
module olmr_serial_div #(
	parameter int unsigned DIVISOR = olmr_pkg::TIMER_CLOCK_HZ,
	parameter int unsigned W = olmr_pkg::QUO_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [W-1:0]                  dividend,
	output logic                          done,
	output logic [W-1:0]                  quotient,
	output logic [$clog2(DIVISOR)-1:0]    remainder
);
	localparam int unsigned RW = $clog2(DIVISOR) + 1;
	localparam int unsigned CW = $clog2(W);
	localparam logic [RW-1:0] DIV_C = RW'(DIVISOR);

	logic [W-1:0]    quo_q;
	logic [RW-2:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW-1:0]   shifted;
	logic            ge;
	logic [RW-1:0]   diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign ge = shifted >= DIV_C;
	assign diff = shifted - DIV_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[RW-2:0] : shifted[RW-2:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

/* design/open_loop_motor_ramp_generator.sv */
// Open-loop start-up ramp: slews current, voltage and velocity, then advances phase and distance.
// An update runs parallel serial multiplies and serial divides for the slew steps, one more multiply
// and divide for the phase step, a serial modulo for the phase wrap, then the output state. A
// restart clears levels, phase, distance and timestamp and goes straight to the output state,
// which registers the all-zero result. One request is in work at a time: no new one is accepted
// until the result is loaded. Reset clears levels, phase, distance, timestamp; loads defaults.
module open_loop_motor_ramp_generator #(
	parameter int unsigned TIMER_CLOCK_HZ = olmr_pkg::TIMER_CLOCK_HZ
) (
	input  logic           clk,
	input  logic           arst_n,
	olmr_sample_if.sink    sample,
	olmr_result_if.source  result,
	olmr_setup_if.sink     setup
);
	localparam int unsigned W = olmr_pkg::OPND_W;
	localparam int unsigned PW = olmr_pkg::PROD_W;
	localparam int unsigned QW = olmr_pkg::QUO_W;
	localparam int unsigned SH = olmr_pkg::PHASE_SHIFT;
	localparam int unsigned L = olmr_pkg::LANES;
	localparam int unsigned MW = $clog2(olmr_pkg::TWO_PIQ);
	localparam logic signed [32:0] TWO_PIQ_S = 33'(olmr_pkg::TWO_PIQ);
	localparam logic signed [32:0] PIQ_S = {1'b0, olmr_pkg::PIQ};

	olmr_pkg::state_t state_q, state_d;

	logic signed [31:0]             tgt_cur_q, tgt_volt_q, tgt_vel_q;
	logic [olmr_pkg::RATE_W-1:0]    rate_q [L];
	logic [31:0]                    ts_q, last_ts_q, ticks_q, ticks_c;
	logic signed [31:0]             cur_q, volt_q, vel_q;
	logic signed [olmr_pkg::PHASE_W-1:0] angle_q;
	logic signed [olmr_pkg::DIST_W-1:0]  dist_q;

	logic                           res_valid_q;
	logic signed [31:0]             res_cur_q, res_volt_q, res_vel_q;
	logic signed [olmr_pkg::PHASE_W-1:0] res_phase_q;
	logic signed [olmr_pkg::DIST_W-1:0]  res_dist_q;

	logic                           accept, restart_acc, run_acc;
	logic                           mul_start, div_start, mod_start, mod_done;
	logic [W-1:0]                   mul_a [L];
	logic                           mul_done [L];
	logic [PW-1:0]                  prod [L];
	logic [QW-1:0]                  div_in [L];
	logic                           div_done [L];
	logic [QW-1:0]                  quo [L];
	logic [MW-1:0]                  mod_rem;

	logic signed [31:0]             tv, tw, cur_new, volt_new, vel_new;
	logic signed [32:0]             wrap_base, wrap_sum;
	logic signed [olmr_pkg::DIST_W-1:0] delta, dist_sum, dist_new;
	logic                           neg, ovf;
	logic                           load_out;

	assign accept = sample.valid && sample.ready;
	assign restart_acc = accept && sample.restart;
	assign run_acc = accept && !sample.restart;
	assign sample.ready = (state_q == olmr_pkg::ST_IDLE);
	assign setup.ready = 1'b1;

	assign ticks_c = (last_ts_q == '0) ? '0 : sample.timestamp - last_ts_q;

	assign mul_start = run_acc || (state_q == olmr_pkg::ST_SLEW);
	assign div_start = ((state_q == olmr_pkg::ST_MUL) || (state_q == olmr_pkg::ST_PMUL))
		&& mul_done[L-1];
	assign mod_start = (state_q == olmr_pkg::ST_PDIV) && div_done[L-1];

	for (genvar i = 0; i < L; i++) begin : g_lane
		assign mul_a[i] = (i == L - 1 && state_q == olmr_pkg::ST_SLEW)
			? olmr_pkg::magnitude(vel_new) : {1'b0, rate_q[i]};
		assign div_in[i] = (state_q == olmr_pkg::ST_PMUL)
			? {prod[i], {SH{1'b0}}} : {{SH{1'b0}}, prod[i]};

		olmr_serial_mul u_mul (
			.clk(clk), .arst_n(arst_n), .start(mul_start),
			.a(mul_a[i]), .b(state_q == olmr_pkg::ST_IDLE ? ticks_c : ticks_q),
			.done(mul_done[i]), .product(prod[i])
		);

		olmr_serial_div #(.DIVISOR(TIMER_CLOCK_HZ), .W(QW)) u_div (
			.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_in[i]),
			.done(div_done[i]), .quotient(quo[i]), .remainder()
		);
	end

	olmr_serial_div #(.DIVISOR(olmr_pkg::TWO_PIQ), .W(PW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(quo[L-1][PW-1:0]),
		.done(mod_done), .quotient(), .remainder(mod_rem)
	);

	assign tv = (tgt_volt_q == '0) ? olmr_pkg::DEFAULT_VOLTAGE : tgt_volt_q;
	assign tw = (tgt_vel_q == '0) ? olmr_pkg::DEFAULT_VELOCITY : tgt_vel_q;
	assign cur_new = olmr_pkg::slew_clamp(cur_q, tgt_cur_q, quo[0][PW-1:0]);
	assign volt_new = olmr_pkg::slew_clamp(volt_q, tv, quo[1][PW-1:0]);
	assign vel_new = olmr_pkg::slew_clamp(vel_q, tw, quo[2][PW-1:0]);

	assign neg = vel_q[31];
	always_comb begin
		wrap_base = {{2{angle_q[olmr_pkg::PHASE_W-1]}}, angle_q} + PIQ_S;
		if (neg) begin
			wrap_sum = wrap_base - {2'b00, mod_rem};
			if (wrap_sum < 0) wrap_sum = wrap_sum + TWO_PIQ_S;
		end else begin
			wrap_sum = wrap_base + {2'b00, mod_rem};
			if (wrap_sum >= TWO_PIQ_S) wrap_sum = wrap_sum - TWO_PIQ_S;
		end
	end

	assign delta = neg ? -$signed(quo[L-1][PW-1:0]) : $signed(quo[L-1][PW-1:0]);
	assign dist_sum = dist_q + delta;
	assign ovf = (dist_q[63] == delta[63]) && (dist_sum[63] != delta[63]);
	assign dist_new = ovf ? (delta[63] ? olmr_pkg::DIST_MIN : olmr_pkg::DIST_MAX) : dist_sum;

	assign load_out = (state_q == olmr_pkg::ST_OUT) && (!res_valid_q || result.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			olmr_pkg::ST_IDLE: begin
				if (restart_acc) state_d = olmr_pkg::ST_OUT;
				else if (run_acc) state_d = olmr_pkg::ST_MUL;
			end
			olmr_pkg::ST_MUL:  if (mul_done[L-1]) state_d = olmr_pkg::ST_DIV;
			olmr_pkg::ST_DIV:  if (div_done[L-1]) state_d = olmr_pkg::ST_SLEW;
			olmr_pkg::ST_SLEW: state_d = olmr_pkg::ST_PMUL;
			olmr_pkg::ST_PMUL: if (mul_done[L-1]) state_d = olmr_pkg::ST_PDIV;
			olmr_pkg::ST_PDIV: if (div_done[L-1]) state_d = olmr_pkg::ST_PMOD;
			olmr_pkg::ST_PMOD: if (mod_done) state_d = olmr_pkg::ST_WRAP;
			olmr_pkg::ST_WRAP: state_d = olmr_pkg::ST_OUT;
			olmr_pkg::ST_OUT:  if (load_out) state_d = olmr_pkg::ST_IDLE;
			default: state_d = olmr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olmr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_cur_q <= '0;
			tgt_volt_q <= olmr_pkg::DEFAULT_VOLTAGE;
			tgt_vel_q <= olmr_pkg::DEFAULT_VELOCITY;
			rate_q[0] <= olmr_pkg::RESET_CURRENT_RATE;
			rate_q[1] <= olmr_pkg::RESET_VOLTAGE_RATE;
			rate_q[2] <= olmr_pkg::RESET_VELOCITY_RATE;
		end else if (setup.valid) begin
			case (setup.index)
				olmr_pkg::REG_TARGET_CURRENT:  tgt_cur_q <= setup.data;
				olmr_pkg::REG_TARGET_VOLTAGE:  tgt_volt_q <= setup.data;
				olmr_pkg::REG_TARGET_VELOCITY: tgt_vel_q <= setup.data;
				olmr_pkg::REG_CURRENT_RATE:    rate_q[0] <= setup.data[olmr_pkg::RATE_W-1:0];
				olmr_pkg::REG_VOLTAGE_RATE:    rate_q[1] <= setup.data[olmr_pkg::RATE_W-1:0];
				olmr_pkg::REG_VELOCITY_RATE:   rate_q[2] <= setup.data[olmr_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ts_q <= '0;
			cur_q <= '0;
			volt_q <= '0;
			vel_q <= '0;
			angle_q <= '0;
			dist_q <= '0;
		end else if (restart_acc) begin
			last_ts_q <= '0;
			cur_q <= '0;
			volt_q <= '0;
			vel_q <= '0;
			angle_q <= '0;
			dist_q <= '0;
		end else if (state_q == olmr_pkg::ST_SLEW) begin
			cur_q <= cur_new;
			volt_q <= volt_new;
			vel_q <= vel_new;
		end else if (state_q == olmr_pkg::ST_WRAP) begin
			angle_q <= olmr_pkg::PHASE_W'(wrap_sum - PIQ_S);
			dist_q <= dist_new;
			last_ts_q <= ts_q;
		end
	end

	always_ff @(posedge clk) begin
		if (run_acc) begin
			ts_q <= sample.timestamp;
			ticks_q <= ticks_c;
		end
		if (load_out) begin
			res_cur_q <= cur_q;
			res_volt_q <= volt_q;
			res_vel_q <= vel_q;
			res_phase_q <= angle_q;
			res_dist_q <= dist_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid = res_valid_q;
	assign result.current_setpoint = res_cur_q;
	assign result.voltage_setpoint = res_volt_q;
	assign result.phase_velocity = res_vel_q;
	assign result.electrical_phase = res_phase_q;
	assign result.travelled_angle = res_dist_q;
endmodule

/* design/olmr_checker.sv */
// Port-level assertions for the ramp generator, attached by bind.
// Depends on olmr_pkg and open_loop_motor_ramp_generator.
module olmr_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [olmr_pkg::PHASE_W-1:0]  phase,
	input logic signed [olmr_pkg::DIST_W-1:0]   distance
);
	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another was in work");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (phase >= olmr_pkg::PHASE_MIN) && (phase <= olmr_pkg::PHASE_MAX))
		else $error("electrical phase outside the wrap range");

	// A new result is only produced at the end of a request's work.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(distance))
		else $error("stalled result changed");
endmodule

bind open_loop_motor_ramp_generator olmr_checker u_olmr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample.valid),
	.in_ready(sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.phase(result.electrical_phase),
	.distance(result.travelled_angle)
);
